>>> design/ehash_pkg.sv
// ---------------------------------------------------------------------------
// ehash_pkg: shared types and codes of the extendible hash table
// Operation and status codes, the stored entry layout, the compare unit
// result and the sequencer states.
// ---------------------------------------------------------------------------
package ehash_pkg;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_BUCKET = 2'd2;
   localparam logic [1:0] ST_DIR_FULL  = 2'd3;

   localparam int SLOT_BITS_RESET = 2;

   typedef struct packed {
      logic [63:0] hash;
      logic [63:0] parent_id;
      logic [63:0] block_id;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic upper;
   } match_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_META,
      S_LOAD,
      S_DECIDE,
      S_FIND_RD,
      S_FIND_CHK,
      S_DEL_RD,
      S_DEL_WR,
      S_SPL_RD,
      S_SPL_WR,
      S_SPL_MB,
      S_SPL_MN,
      S_DSWEEP,
      S_SPL_NEXT,
      S_DONE
   } state_type;

endpackage

>>> design/ehash_ram.sv
// ---------------------------------------------------------------------------
// ehash_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ehash_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ehash_match.sv
// ---------------------------------------------------------------------------
// ehash_match: shared entry compare unit
// Compares a stored entry with the current key under the slot mask and
// picks the hash bit that decides which half of a split the entry goes to.
// ---------------------------------------------------------------------------
module ehash_match #(
   parameter int LDW = 4
) (
   input  ehash_pkg::entry_type ent,
   input  ehash_pkg::entry_type key,
   input  logic [3:0]           sb,
   input  logic [LDW-1:0]       bit_sel,
   output ehash_pkg::match_type result
);
   import ehash_pkg::*;

   logic [63:0] mask;
   logic [6:0]  shidx;

   always_comb begin
      mask         = ~(64'hFFFF_FFFF_FFFF_FFFF << sb);
      shidx        = 7'(sb) + 7'(bit_sel);
      result.hit   = (((ent.hash ^ key.hash) & mask) == 64'd0) &&
                     (ent.parent_id == key.parent_id) &&
                     (ent.block_id == key.block_id);
      result.upper = ent.hash[shidx[5:0]];
   end

endmodule

>>> design/extendible_hash_table.sv
// ---------------------------------------------------------------------------
// extendible_hash_table: extendible hash table engine
// Lookup, insert and delete of two-word keys with a precomputed hash, over
// a directory, per-bucket depth and fill counts, and an entry store.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Contents
//   req_     in         req_valid/req_stall  op, hash, parent_id, block_id
//   rsp_     out        rsp_valid/rsp_stall  status, bucket_number, slot_number
//   csr_     in         csr_valid/csr_ready  slot_bits
//
// A lookup or delete reads the directory, the bucket table and then the
// bucket's entries from the newest down; a delete also moves each later
// entry down by one slot. An insert without a split writes the key at the
// bucket's fill position; each split rewrites every entry of the full bucket
// and then walks every directory entry. After reset a clearing pass zeroes
// the directory and bucket table; no request transfer is taken then.
// The request side stalls while an item is in work. A finished result sits
// in the output register until taken, and the next request may be taken
// while it waits.
// ---------------------------------------------------------------------------
module extendible_hash_table #(
   parameter int MAX_DIR_DEPTH = 10,
   parameter int MAX_BUCKETS   = 64,
   parameter int MAX_SLOT_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_hash,
   input  logic [63:0] req_parent_id,
   input  logic [63:0] req_block_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_bucket_number,
   output logic [3:0]  rsp_slot_number,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_slot_bits
);
   import ehash_pkg::*;

   // Derived sizes.
   localparam int DD    = MAX_DIR_DEPTH;
   localparam int DIR_N = 1 << DD;
   localparam int NB    = MAX_BUCKETS;
   localparam int BW    = $clog2(NB);
   localparam int UW    = $clog2(NB + 1);
   localparam int POOL  = 2 << MAX_SLOT_BITS;
   localparam int PW    = $clog2(POOL);
   localparam int FW    = $clog2(POOL + 1);
   localparam int LDW   = $clog2(DD + 2);
   localparam int MW    = LDW + FW;
   localparam int EW    = $bits(entry_type);
   localparam int CLR_N = (DIR_N > NB) ? DIR_N : NB;
   localparam int CW    = $clog2(CLR_N);

   // Control and configuration registers.
   state_type      state_ff, state_in;
   logic [CW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [2:0]     slot_bits_ff, slot_bits_in;
   logic [LDW-1:0] gd_ff, gd_in;
   logic [UW-1:0]  used_ff, used_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Working registers of the current item.
   logic [1:0]     op_ff, op_in;
   entry_type      key_ff, key_in;
   logic [3:0]     sb_ff, sb_in;
   logic [BW-1:0]  b_ff, b_in;
   logic [BW-1:0]  nb_ff, nb_in;
   logic [LDW-1:0] ld_ff, ld_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [FW-1:0]  pos_ff, pos_in;
   logic [FW-1:0]  keep_ff, keep_in;
   logic [FW-1:0]  nfill_ff, nfill_in;
   logic [DD:0]    ds_cnt_ff, ds_cnt_in;
   logic [1:0]     status_ff, status_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [5:0]     rsp_bucket_ff, rsp_bucket_in;
   logic [3:0]     rsp_slot_ff, rsp_slot_in;

   // Memory ports.
   logic             dir_we;
   logic [DD-1:0]    dir_waddr, dir_raddr;
   logic [BW-1:0]    dir_wdata, dir_q;
   logic             meta_we;
   logic [BW-1:0]    meta_waddr, meta_raddr;
   logic [MW-1:0]    meta_wdata, meta_q;
   logic             ent_we;
   logic [BW+PW-1:0] ent_waddr, ent_raddr;
   entry_type        ent_wdata, ent_q;

   match_type        mres;

   // Helpers.
   logic           accept;
   logic [3:0]     eff_sb;
   logic [63:0]    hs;
   logic [DD-1:0]  dir_idx;
   logic [FW-1:0]  cap;
   logic [LDW-1:0] nd;
   logic [DD-1:0]  prev_idx;

   ehash_ram #(.WIDTH(BW), .DEPTH(DIR_N)) u_dir (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_addr (dir_raddr),
      .rd_data (dir_q)
   );

   ehash_ram #(.WIDTH(MW), .DEPTH(NB)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (meta_raddr),
      .rd_data (meta_q)
   );

   ehash_ram #(.WIDTH(EW), .DEPTH(NB * POOL)) u_ent (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_q)
   );

   // The one compare unit serves the key search and the split partition.
   ehash_match #(.LDW(LDW)) u_match (
      .ent     (ent_q),
      .key     (key_ff),
      .sb      (sb_ff),
      .bit_sel (ld_ff),
      .result  (mres)
   );

   assign req_stall         = (state_ff != S_IDLE);
   assign accept            = req_valid && !req_stall;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_bucket_number = rsp_bucket_ff;
   assign rsp_slot_number   = rsp_slot_ff;

   always_comb begin
      // A slot_bits value above the maximum acts as the maximum.
      eff_sb   = (4'(slot_bits_ff) > 4'(MAX_SLOT_BITS)) ? 4'(MAX_SLOT_BITS)
                                                        : 4'(slot_bits_ff);
      hs       = key_ff.hash >> sb_ff;
      dir_idx  = hs[DD-1:0] & ~({DD{1'b1}} << gd_ff);
      cap      = FW'(2) << sb_ff;
      nd       = ld_ff + LDW'(1);
      prev_idx = DD'(ds_cnt_ff - (DD + 1)'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         slot_bits_ff <= 3'(SLOT_BITS_RESET);
         gd_ff        <= '0;
         used_ff      <= UW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         slot_bits_ff <= slot_bits_in;
         gd_ff        <= gd_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      sb_ff         <= sb_in;
      b_ff          <= b_in;
      nb_ff         <= nb_in;
      ld_ff         <= ld_in;
      fill_ff       <= fill_in;
      pos_ff        <= pos_in;
      keep_ff       <= keep_in;
      nfill_ff      <= nfill_in;
      ds_cnt_ff     <= ds_cnt_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      slot_bits_in  = slot_bits_ff;
      gd_in         = gd_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      sb_in         = sb_ff;
      b_in          = b_ff;
      nb_in         = nb_ff;
      ld_in         = ld_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      keep_in       = keep_ff;
      nfill_in      = nfill_ff;
      ds_cnt_in     = ds_cnt_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      dir_we     = 1'b0;
      dir_waddr  = '0;
      dir_wdata  = '0;
      dir_raddr  = '0;
      meta_we    = 1'b0;
      meta_waddr = '0;
      meta_wdata = '0;
      meta_raddr = '0;
      ent_we     = 1'b0;
      ent_waddr  = '0;
      ent_wdata  = key_ff;
      ent_raddr  = '0;

      if (csr_valid && csr_ready) begin
         slot_bits_in = csr_slot_bits;
      end

      unique case (state_ff)
         // Zero the directory and the bucket table after reset.
         S_CLEAR: begin
            if (clr_cnt_ff <= CW'(DIR_N - 1)) begin
               dir_we    = 1'b1;
               dir_waddr = clr_cnt_ff[DD-1:0];
            end
            if (clr_cnt_ff <= CW'(NB - 1)) begin
               meta_we    = 1'b1;
               meta_waddr = clr_cnt_ff[BW-1:0];
            end
            if (clr_cnt_ff == CW'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + CW'(1);
            end
         end

         S_IDLE: begin
            if (accept) begin
               op_in            = req_op;
               key_in.hash      = req_hash;
               key_in.parent_id = req_parent_id;
               key_in.block_id  = req_block_id;
               sb_in            = eff_sb;
               state_in         = S_DIR;
            end
         end

         S_DIR: begin
            dir_raddr = dir_idx;
            state_in  = S_META;
         end

         S_META: begin
            meta_raddr = dir_q;
            b_in       = dir_q;
            state_in   = S_LOAD;
         end

         S_LOAD: begin
            ld_in    = meta_q[MW-1:FW];
            fill_in  = meta_q[FW-1:0];
            state_in = S_DECIDE;
         end

         // Dispatch on the operation with the current bucket's depth and fill.
         S_DECIDE: begin
            if (op_ff == OP_INSERT) begin
               if (fill_ff >= cap) begin
                  if (ld_ff >= LDW'(DD)) begin
                     status_in = ST_DIR_FULL;
                     state_in  = S_DONE;
                  end else if (used_ff >= UW'(NB)) begin
                     status_in = ST_NO_BUCKET;
                     state_in  = S_DONE;
                  end else begin
                     nb_in    = used_ff[BW-1:0];
                     used_in  = used_ff + UW'(1);
                     pos_in   = '0;
                     keep_in  = '0;
                     nfill_in = '0;
                     state_in = S_SPL_RD;
                  end
               end else begin
                  ent_we     = 1'b1;
                  ent_waddr  = {b_ff, fill_ff[PW-1:0]};
                  meta_we    = 1'b1;
                  meta_waddr = b_ff;
                  meta_wdata = {ld_ff, fill_ff + FW'(1)};
                  status_in  = ST_OK;
                  state_in   = S_DONE;
               end
            end else if (fill_ff == '0) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               pos_in   = fill_ff - FW'(1);
               state_in = S_FIND_RD;
            end
         end

         // Search from the newest entry down.
         S_FIND_RD: begin
            ent_raddr = {b_ff, pos_ff[PW-1:0]};
            state_in  = S_FIND_CHK;
         end

         S_FIND_CHK: begin
            if (mres.hit) begin
               if (op_ff == OP_DELETE) begin
                  state_in = S_DEL_RD;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end
            end else if (pos_ff == '0) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               pos_in   = pos_ff - FW'(1);
               state_in = S_FIND_RD;
            end
         end

         // Close the gap left by the deleted entry, one entry per pass.
         S_DEL_RD: begin
            if (pos_ff + FW'(1) < fill_ff) begin
               ent_raddr = {b_ff, PW'(pos_ff + FW'(1))};
               state_in  = S_DEL_WR;
            end else begin
               meta_we    = 1'b1;
               meta_waddr = b_ff;
               meta_wdata = {ld_ff, fill_ff - FW'(1)};
               status_in  = ST_OK;
               state_in   = S_DONE;
            end
         end

         S_DEL_WR: begin
            ent_we    = 1'b1;
            ent_waddr = {b_ff, pos_ff[PW-1:0]};
            ent_wdata = ent_q;
            pos_in    = pos_ff + FW'(1);
            state_in  = S_DEL_RD;
         end

         // Partition the full bucket on hash bit ld_ff above the slot bits.
         S_SPL_RD: begin
            if (pos_ff == fill_ff) begin
               state_in = S_SPL_MB;
            end else begin
               ent_raddr = {b_ff, pos_ff[PW-1:0]};
               state_in  = S_SPL_WR;
            end
         end

         S_SPL_WR: begin
            ent_we    = 1'b1;
            ent_wdata = ent_q;
            if (mres.upper) begin
               ent_waddr = {nb_ff, nfill_ff[PW-1:0]};
               nfill_in  = nfill_ff + FW'(1);
            end else begin
               ent_waddr = {b_ff, keep_ff[PW-1:0]};
               keep_in   = keep_ff + FW'(1);
            end
            pos_in   = pos_ff + FW'(1);
            state_in = S_SPL_RD;
         end

         S_SPL_MB: begin
            meta_we    = 1'b1;
            meta_waddr = b_ff;
            meta_wdata = {nd, keep_ff};
            state_in   = S_SPL_MN;
         end

         S_SPL_MN: begin
            meta_we    = 1'b1;
            meta_waddr = nb_ff;
            meta_wdata = {nd, nfill_ff};
            ds_cnt_in  = '0;
            state_in   = S_DSWEEP;
         end

         // Directory walk: read entry n while rewriting entry n-1.
         S_DSWEEP: begin
            dir_raddr = ds_cnt_ff[DD-1:0];
            if (ds_cnt_ff != '0 && dir_q == b_ff && prev_idx[ld_ff]) begin
               dir_we    = 1'b1;
               dir_waddr = prev_idx;
               dir_wdata = nb_ff;
            end
            if (ds_cnt_ff == (DD + 1)'(DIR_N)) begin
               state_in = S_SPL_NEXT;
            end else begin
               ds_cnt_in = ds_cnt_ff + (DD + 1)'(1);
            end
         end

         // Follow the half that takes the new key and check it again.
         S_SPL_NEXT: begin
            if (nd > gd_ff) begin
               gd_in = nd;
            end
            if (hs[ld_ff]) begin
               b_in    = nb_ff;
               fill_in = nfill_ff;
            end else begin
               fill_in = keep_ff;
            end
            ld_in    = nd;
            state_in = S_DECIDE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_bucket_in = 6'(b_ff);
               rsp_slot_in   = key_ff.hash[3:0] & ~(4'hF << sb_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> design/ehash_checker.sv
// ---------------------------------------------------------------------------
// ehash_checker: port-level checks of the extendible hash table
// Watches the handshakes of the top level and is bound to it.
// ---------------------------------------------------------------------------
module ehash_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_bucket_number,
   input logic [3:0] rsp_slot_number
);

   // A stalled result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_bucket_number) && $stable(rsp_slot_number))
      else $error("result changed while stalled");

   // An accepted request makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous still in work");

   // The clearing pass after reset takes no request.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open right after reset");

endmodule

bind extendible_hash_table ehash_checker u_ehash_checker (.*);

>>> tb/tb_extendible_hash_table.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_extendible_hash_table: self-checking bench for the hash table engine
// Drives lookups, inserts and deletes with random handshake gaps. A
// behavioral copy of the table predicts each response, and a small
// scoreboard compares every response transfer against it in order.
// ---------------------------------------------------------------------------

module tb_extendible_hash_table;
   import ehash_pkg::*;

   localparam int GD_MAX     = 10;
   localparam int NUM_BKT    = 64;
   localparam int SLOT_MAX   = 4;
   localparam int DIR_SIZE   = 1 << GD_MAX;
   localparam int POOL       = 2 << SLOT_MAX;
   localparam int RANDOM_CNT = 1600;

   // One predicted response.
   typedef struct packed {
      logic [1:0] status;
      logic [5:0] bucket;
      logic [3:0] slot;
   } rsp_type;

   // The scoreboard keeps the responses still owed by the engine.
   class rsp_scoreboard;
      rsp_type pending[$];
      int      errors;

      function void note_request(rsp_type r);
         pending.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing pending: got %p", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                     got.status);
            errors++;
         end
         if (got.bucket !== want.bucket) begin
            $display("%0t: bucket expected %0d actual %0d", $realtime, want.bucket,
                     got.bucket);
            errors++;
         end
         if (got.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $realtime, want.slot,
                     got.slot);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_LOOKUP;
   logic [63:0] req_hash = '0;
   logic [63:0] req_parent_id = '0;
   logic [63:0] req_block_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_bucket_number;
   logic [3:0]  rsp_slot_number;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_slot_bits = '0;

   extendible_hash_table u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_hash          (req_hash),
      .req_parent_id     (req_parent_id),
      .req_block_id      (req_block_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_bucket_number (rsp_bucket_number),
      .rsp_slot_number   (rsp_slot_number),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_slot_bits     (csr_slot_bits)
   );

   always #1 clock = ~clock;

   rsp_scoreboard board = new();

   // Behavioral copy of the table state.
   logic [2:0]  slot_bits_reg;
   int          glob_depth;
   int          dir_map [DIR_SIZE];
   int          bkt_used;
   int          bkt_depth [NUM_BKT];
   int          bkt_fill [NUM_BKT];
   logic        ent_live [NUM_BKT * POOL];
   logic [63:0] ent_hash [NUM_BKT * POOL];
   logic [63:0] ent_par [NUM_BKT * POOL];
   logic [63:0] ent_blk [NUM_BKT * POOL];

   // Keys that were inserted, reused by the stimulus to produce hits.
   logic [63:0] known_hash[$];
   logic [63:0] known_par[$];
   logic [63:0] known_blk[$];

   // Receiver hold-off request from the stimulus process.
   int  hold_cycles = 0;
   bit  stim_done = 0;

   function automatic void table_clear();
      slot_bits_reg = 3'(SLOT_BITS_RESET);
      glob_depth = 0;
      bkt_used = 1;
      foreach (dir_map[i]) dir_map[i] = 0;
      foreach (bkt_depth[i]) begin
         bkt_depth[i] = 0;
         bkt_fill[i] = 0;
      end
      foreach (ent_live[i]) begin
         ent_live[i] = 0;
         ent_hash[i] = '0;
         ent_par[i] = '0;
         ent_blk[i] = '0;
      end
   endfunction

   function automatic void move_entry(int dst, int src);
      ent_live[dst] = ent_live[src];
      ent_hash[dst] = ent_hash[src];
      ent_par[dst] = ent_par[src];
      ent_blk[dst] = ent_blk[src];
   endfunction

   // Computes the response of one request and applies it to the table copy.
   function automatic rsp_type table_apply(logic [1:0] op, logic [63:0] hash,
                                           logic [63:0] par, logic [63:0] blk);
      int         sb, bkt, pos, n, keep, nb, bitpos, old_n, src;
      logic [63:0] mask;
      rsp_type    r;
      sb = (slot_bits_reg > SLOT_MAX) ? SLOT_MAX : int'(slot_bits_reg);
      mask = (64'd1 << sb) - 64'd1;
      r.slot = 4'(hash & mask);
      bkt = dir_map[int'((hash >> sb) & ((64'd1 << glob_depth) - 64'd1))];
      r.status = ST_OK;
      if (op == OP_INSERT) begin
         // Split until the bucket that takes this hash has room.
         while (bkt_fill[bkt] >= (2 << sb) && r.status == ST_OK) begin
            if (bkt_depth[bkt] + 1 > GD_MAX) begin
               r.status = ST_DIR_FULL;
            end else if (bkt_used >= NUM_BKT) begin
               r.status = ST_NO_BUCKET;
            end else begin
               nb = bkt_used;
               bkt_used = bkt_used + 1;
               bitpos = bkt_depth[bkt];
               bkt_depth[bkt] = bitpos + 1;
               bkt_depth[nb] = bitpos + 1;
               bkt_fill[nb] = 0;
               keep = 0;
               old_n = (bkt_fill[bkt] > POOL) ? POOL : bkt_fill[bkt];
               for (int i = 0; i < old_n; i++) begin
                  src = bkt * POOL + i;
                  if (((ent_hash[src] >> sb) >> bitpos) & 64'd1) begin
                     move_entry(nb * POOL + bkt_fill[nb], src);
                     bkt_fill[nb] = bkt_fill[nb] + 1;
                  end else begin
                     move_entry(bkt * POOL + keep, src);
                     keep = keep + 1;
                  end
               end
               for (int i = keep; i < old_n; i++) ent_live[bkt * POOL + i] = 0;
               bkt_fill[bkt] = keep;
               for (int i = 0; i < DIR_SIZE; i++)
                  if (dir_map[i] == bkt && ((i >> bitpos) & 1)) dir_map[i] = nb;
               if (bitpos + 1 > glob_depth) glob_depth = bitpos + 1;
               if (((hash >> sb) >> bitpos) & 64'd1) bkt = nb;
            end
         end
         if (r.status == ST_OK && bkt_fill[bkt] < POOL) begin
            pos = bkt * POOL + bkt_fill[bkt];
            ent_live[pos] = 1;
            ent_hash[pos] = hash;
            ent_par[pos] = par;
            ent_blk[pos] = blk;
            bkt_fill[bkt] = bkt_fill[bkt] + 1;
         end
      end else begin
         // Lookup, delete and the reserved code search newest first.
         pos = -1;
         n = (bkt_fill[bkt] > POOL) ? POOL : bkt_fill[bkt];
         for (int i = n - 1; i >= 0 && pos < 0; i--) begin
            src = bkt * POOL + i;
            if (ent_live[src] && (ent_hash[src] & mask) == (hash & mask) &&
                ent_par[src] == par && ent_blk[src] == blk)
               pos = i;
         end
         if (pos < 0) begin
            r.status = ST_NOT_FOUND;
         end else if (op == OP_DELETE) begin
            n = bkt_fill[bkt];
            for (int i = pos; i + 1 < n; i++)
               move_entry(bkt * POOL + i, bkt * POOL + i + 1);
            ent_live[bkt * POOL + n - 1] = 0;
            bkt_fill[bkt] = n - 1;
         end
      end
      r.bucket = 6'(bkt);
      return r;
   endfunction

   // Offers one request after a random gap and waits for its transfer.
   // Valid stays high after a transfer when the next request follows at once.
   task automatic send_request(logic [1:0] op, logic [63:0] hash,
                               logic [63:0] par, logic [63:0] blk);
      int gap;
      gap = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_hash <= hash;
      req_parent_id <= par;
      req_block_id <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(table_apply(op, hash, par, blk));
      if (op == OP_INSERT) begin
         known_hash.push_back(hash);
         known_par.push_back(par);
         known_blk.push_back(blk);
         if (known_hash.size() > 48) begin
            void'(known_hash.pop_front());
            void'(known_par.pop_front());
            void'(known_blk.pop_front());
         end
      end
   endtask

   // Waits until every response has come, then for the engine to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   // Writes the slot_bits register with the engine idle.
   task automatic write_slot_bits(logic [2:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_slot_bits <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      slot_bits_reg = value;
   endtask

   // One random request: mostly inserts and hits on known keys, some noise.
   task automatic random_request(int hash_bits);
      logic [1:0]  op;
      logic [63:0] hash, par, blk;
      int          k;
      op = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 5 && known_hash.size() != 0 && op != OP_INSERT) begin
         k = $urandom_range(0, known_hash.size() - 1);
         hash = known_hash[k];
         par = known_par[k];
         blk = known_blk[k];
      end else begin
         hash = {$urandom, $urandom};
         if (hash_bits < 64) hash = hash & ((64'd1 << hash_bits) - 64'd1);
         par = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 3));
         blk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 3));
         if ($urandom_range(0, 2) == 0) op = OP_INSERT;
      end
      send_request(op, hash, par, blk);
   endtask

   // Response side: random stall lengths, plus a long hold-off on request.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response({rsp_status, rsp_bucket_number, rsp_slot_number});
   end

   // Stimulus.
   initial begin
      logic [63:0] ones;
      ones = '1;
      table_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, each operation, reserved code, duplicates.
      send_request(OP_LOOKUP, 64'd0, 64'd0, 64'd0);
      send_request(OP_INSERT, 64'd0, 64'd0, 64'd0);
      send_request(OP_INSERT, 64'd0, 64'd0, 64'd0);
      send_request(OP_INSERT, ones, ones, ones);
      send_request(OP_LOOKUP, ones, ones, ones);
      send_request(2'd3, ones, ones, ones);
      send_request(2'd3, 64'd5, 64'd1, 64'd1);
      send_request(OP_DELETE, 64'd0, 64'd0, 64'd0);
      send_request(OP_LOOKUP, 64'd0, 64'd0, 64'd0);
      send_request(OP_DELETE, 64'd0, 64'd0, 64'd0);
      send_request(OP_DELETE, 64'd0, 64'd0, 64'd0);
      send_request(OP_DELETE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'h5555_5555_5555_5555);
      for (int i = 0; i < 10; i++)
         send_request(OP_INSERT, 64'(i) << 2, 64'(i), ones);
      send_request(OP_LOOKUP, 64'd36, 64'd9, ones);

      // Directory exhaustion: identical hashes can never separate.
      write_slot_bits(3'd0);
      for (int i = 0; i < 14; i++) send_request(OP_INSERT, 64'd0, 64'(i), 64'd7);

      // Random phases over several register settings, extremes included.
      for (int phase = 0; phase < 8; phase++) begin
         // Restrict hashes in phase 2 so buckets overflow and split.
         write_slot_bits(3'(phase == 0 ? 7 : (phase == 1 ? 4 : $urandom_range(0, 7))));
         for (int i = 0; i < RANDOM_CNT / 8; i++) begin
            if (phase == 3 && i == 20) hold_cycles = 300;
            if (phase == 5 && i == 40) begin
               req_valid <= 1'b0;
               while (board.pending.size() != 0) @(posedge clock);
            end
            random_request(phase == 2 ? 12 : 64);
         end
      end
      write_slot_bits(3'd2);
      repeat (20) random_request(64);

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: far above the slowest legal run, splits included.
   initial begin
      #40000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
